/* rtl/i4dq_pkg.sv */
// Shared types, register codes and float helper functions for the int4 dequantizer.
// Depends on nothing; used by every module in rtl/.
package i4dq_pkg;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAYER_SCALE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_HALF = 2'd1;

   localparam logic [31:0] QNAN_F32 = 32'h7FC0_0000;
   localparam logic [31:0] INF_F32  = 32'h7F80_0000;

   typedef enum logic [1:0] {
      CLS_NUM  = 2'd0,
      CLS_ZERO = 2'd1,
      CLS_INF  = 2'd2,
      CLS_NAN  = 2'd3
   } cls_type;

   // unpacked operand: value = mant * 2^(expo-150)
   typedef struct packed {
      logic        sign;
      logic [7:0]  expo;
      logic [23:0] mant;
      logic        is_zero;
      logic        is_inf;
      logic        is_nan;
   } fp_op_type;

   typedef struct packed {
      fp_op_type   w_op;
      logic [31:0] bscale;
   } q_item_type;

   typedef struct packed {
      logic               sign;
      cls_type            cls;
      logic [47:0]        prod;
      logic signed [10:0] esum;
   } m1_type;

   typedef struct packed {
      logic               sign;
      cls_type            cls;
      logic [47:0]        prod;
      logic signed [10:0] e;
      logic signed [10:0] sh;
   } m2_type;

   typedef struct packed {
      logic        sign;
      cls_type     cls;
      logic        ovf;
      logic [7:0]  expf;
      logic [47:0] n;
      logic        sticky;
   } m3_type;

   function automatic fp_op_type unpack_f32(input logic [31:0] x);
      fp_op_type o;
      o.sign    = x[31];
      o.expo    = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
      o.mant    = {x[30:23] != 8'd0, x[22:0]};
      o.is_zero = (x[30:0] == 31'd0);
      o.is_inf  = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
      o.is_nan  = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
      return o;
   endfunction

   // stage 1: classify and form the raw mantissa product
   function automatic m1_type fmul_s1(input fp_op_type a, input fp_op_type b);
      m1_type r;
      r.sign = a.sign ^ b.sign;
      if (a.is_nan || b.is_nan || (a.is_inf && b.is_zero) || (a.is_zero && b.is_inf)) begin
         r.cls = CLS_NAN;
      end else if (a.is_inf || b.is_inf) begin
         r.cls = CLS_INF;
      end else if (a.is_zero || b.is_zero) begin
         r.cls = CLS_ZERO;
      end else begin
         r.cls = CLS_NUM;
      end
      r.prod = 48'(a.mant) * 48'(b.mant);
      r.esum = $signed(11'(a.expo)) + $signed(11'(b.expo)) - 11'sd126;
      return r;
   endfunction

   // stage 2: leading zero count, result exponent and shift amount
   function automatic m2_type fmul_s2(input m1_type m);
      m2_type r;
      logic [5:0] lz;
      lz = 6'd0;
      for (int i = 0; i < 48; i++) begin
         if (m.prod[i]) lz = 6'(47 - i);
      end
      r.sign = m.sign;
      r.cls  = m.cls;
      r.prod = m.prod;
      r.e    = m.esum - $signed(11'(lz));
      r.sh   = (r.e < 11'sd1) ? (m.esum - 11'sd1) : $signed(11'(lz));
      return r;
   endfunction

   // stage 3: normalize, or denormalize with sticky
   function automatic m3_type fmul_s3(input m2_type m);
      m3_type r;
      logic [10:0] rs;
      r.sign   = m.sign;
      r.cls    = m.cls;
      r.sticky = 1'b0;
      rs       = 11'(-m.sh);
      if (!m.sh[10]) begin
         r.n = m.prod << m.sh[5:0];
      end else if (rs >= 11'd48) begin
         r.n      = 48'd0;
         r.sticky = |m.prod;
      end else begin
         r.n      = m.prod >> rs[5:0];
         r.sticky = |(m.prod << (7'd48 - {1'b0, rs[5:0]}));
      end
      r.ovf  = (m.e >= 11'sd255);
      r.expf = (m.e >= 11'sd1) ? m.e[7:0] : 8'd0;
      return r;
   endfunction

   // stage 4: round to nearest even and pack
   function automatic logic [31:0] fmul_s4(input m3_type m);
      logic [30:0] mag;
      logic        up;
      logic [31:0] r;
      up  = m.n[23] & ((|m.n[22:0]) | m.sticky | m.n[24]);
      mag = {m.expf, m.n[46:24]} + 31'(up);
      case (m.cls)
         CLS_NAN:  r = QNAN_F32;
         CLS_INF:  r = {m.sign, INF_F32[30:0]};
         CLS_ZERO: r = {m.sign, 31'd0};
         default:  r = m.ovf ? {m.sign, INF_F32[30:0]} : {m.sign, mag};
      endcase
      return r;
   endfunction

   function automatic logic [15:0] to_half(input logic [31:0] x);
      logic               sign;
      logic [22:0]        frac;
      logic signed [9:0]  hexp;
      logic [23:0]        m;
      logic [4:0]         sh;
      logic [23:0]        hv;
      logic [23:0]        rem;
      logic [23:0]        halfway;
      logic [14:0]        h;
      logic [15:0]        r;
      sign    = x[31];
      frac    = x[22:0];
      hexp    = $signed(10'(x[30:23])) - 10'sd112;
      m       = {1'b1, frac};
      sh      = 5'(10'sd14 - hexp);
      hv      = m >> sh;
      rem     = m & ((24'd1 << sh) - 24'd1);
      halfway = 24'd1 << (sh - 5'd1);
      h       = {hexp[4:0], frac[22:13]};
      if (x[30:23] == 8'hFF) begin
         r = {sign, 5'h1F, (frac != 23'd0), 9'd0};
      end else if (hexp >= 10'sd31) begin
         r = {sign, 15'h7C00};
      end else if (hexp <= 10'sd0) begin
         if (hexp < -10'sd10) begin
            r = {sign, 15'd0};
         end else if (rem > halfway || (rem == halfway && hv[0])) begin
            r = {sign, hv[14:0] + 15'd1};
         end else begin
            r = {sign, hv[14:0]};
         end
      end else if (frac[12:0] > 13'h1000 || (frac[12:0] == 13'h1000 && h[0])) begin
         r = {sign, h + 15'd1};
      end else begin
         r = {sign, h};
      end
      return r;
   endfunction

endpackage

/* rtl/i4dq_front.sv */
// Front end: takes requests, picks the nibble, forms a sign-magnitude weight operand.
// Depends on i4dq_pkg.
module i4dq_front
   import i4dq_pkg::*;
(
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_packed_byte,
   input  logic        req_high_nibble,
   input  logic [31:0] req_col_scale,
   output logic        push_valid,
   input  logic        push_ready,
   output q_item_type  push_item
);

   logic [3:0] nib;
   logic [3:0] mag;

   assign nib = req_high_nibble ? req_packed_byte[7:4] : req_packed_byte[3:0];
   assign mag = nib[3] ? 4'(-nib) : nib;

   always_comb begin
      push_item.w_op.sign    = nib[3];
      push_item.w_op.expo    = 8'd150;   // integer weight: mant * 2^0
      push_item.w_op.mant    = 24'(mag);
      push_item.w_op.is_zero = (nib == 4'd0);
      push_item.w_op.is_inf  = 1'b0;
      push_item.w_op.is_nan  = 1'b0;
      push_item.bscale       = req_col_scale;
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

/* rtl/i4dq_fifo.sv */
// Short register queue between front and back ends.
// Depends on i4dq_pkg.
module i4dq_fifo
   import i4dq_pkg::*;
#(
   parameter int unsigned DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   output logic       push_ready,
   input  q_item_type push_item,
   output logic       pop_valid,
   input  logic       pop_ready,
   output q_item_type pop_item
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   q_item_type       mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/i4dq_back.sv */
// Back end: two pipelined fp32 multiplies, NaN canonicalization, optional fp16 conversion.
// Depends on i4dq_pkg.
module i4dq_back
   import i4dq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] post_scale,
   input  logic        output_half,
   input  logic        pop_valid,
   output logic        pop_ready,
   input  q_item_type  pop_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_value_bits
);

   localparam int unsigned NSTG = 9;

   logic [NSTG-1:0] v_ff, v_in;
   logic [NSTG-1:0] rdy;

   m1_type      a1_ff, a1_in;
   m2_type      a2_ff, a2_in;
   m3_type      a3_ff, a3_in;
   logic [31:0] p1_ff, p1_in;
   m1_type      b1_ff, b1_in;
   m2_type      b2_ff, b2_in;
   m3_type      b3_ff, b3_in;
   logic [31:0] p2_ff, p2_in;
   logic [31:0] out_ff, out_in;

   always_comb begin
      rdy[NSTG-1] = !v_ff[NSTG-1] || rsp_ready;
      for (int i = NSTG - 2; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
      v_in[0] = pop_valid;
      for (int i = 1; i < NSTG; i++) begin
         v_in[i] = v_ff[i-1];
      end
   end

   assign pop_ready = rdy[0];

   always_comb begin
      a1_in = fmul_s1(pop_item.w_op, unpack_f32(pop_item.bscale));
      a2_in = fmul_s2(a1_ff);
      a3_in = fmul_s3(a2_ff);
      p1_in = fmul_s4(a3_ff);
      b1_in = fmul_s1(unpack_f32(p1_ff), unpack_f32(post_scale));
      b2_in = fmul_s2(b1_ff);
      b3_in = fmul_s3(b2_ff);
      p2_in = fmul_s4(b3_ff);
      out_in = output_half ? {16'd0, to_half(p2_ff)} : p2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (rdy[i]) v_ff[i] <= v_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) a1_ff  <= a1_in;
      if (rdy[1]) a2_ff  <= a2_in;
      if (rdy[2]) a3_ff  <= a3_in;
      if (rdy[3]) p1_ff  <= p1_in;
      if (rdy[4]) b1_ff  <= b1_in;
      if (rdy[5]) b2_ff  <= b2_in;
      if (rdy[6]) b3_ff  <= b3_in;
      if (rdy[7]) p2_ff  <= p2_in;
      if (rdy[8]) out_ff <= out_in;
   end

   assign rsp_valid      = v_ff[NSTG-1];
   assign rsp_value_bits = out_ff;

endmodule

/* rtl/int4_block_dequant_to_half.sv */
// Top level of the int4 block dequantizer: config registers, front end, queue, back end.
// Depends on i4dq_pkg, i4dq_front, i4dq_fifo, i4dq_back.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   request | req_valid/ready, packed_byte,           | in
//           | high_nibble, col_scale                  |
//   result  | rsp_valid/ready, rsp_value_bits         | out
//   csr     | csr_valid/ready, csr_index, csr_data    | in
//
// One request per cycle sustained while rsp_ready stays high; from acceptance a request
// passes the queue, then 4 stages per fp32 multiply plus output, to rsp_valid.
// Synchronous active-high reset clears the pipeline, queue and csr values
// (post scale = 1.0, output_half = 1). A stalled result stalls the back end
// stage by stage; the queue keeps taking requests until it is full.
module int4_block_dequant_to_half
   import i4dq_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_packed_byte,
   input  logic                   req_high_nibble,
   input  logic [31:0]            req_col_scale,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [31:0]            rsp_value_bits,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data
);

   logic [31:0] post_scale_ff, post_scale_in;
   logic        output_half_ff, output_half_in;

   logic        push_valid, push_ready;
   q_item_type  push_item;
   logic        pop_valid, pop_ready;
   q_item_type  pop_item;

   // csr writes always complete; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      post_scale_in  = post_scale_ff;
      output_half_in = output_half_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LAYER_SCALE: post_scale_in  = csr_data;
            CSR_OUTPUT_HALF: output_half_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         post_scale_ff  <= 32'h3F80_0000;
         output_half_ff <= 1'b1;
      end else begin
         post_scale_ff  <= post_scale_in;
         output_half_ff <= output_half_in;
      end
   end

   i4dq_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_packed_byte (req_packed_byte),
      .req_high_nibble (req_high_nibble),
      .req_col_scale   (req_col_scale),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_item       (push_item)
   );

   i4dq_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   i4dq_back u_back (
      .clock          (clock),
      .reset          (reset),
      .post_scale     (post_scale_ff),
      .output_half    (output_half_ff),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_item       (pop_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value_bits (rsp_value_bits)
   );

endmodule
